// File: hdl/adfp_pkg.sv
// ----------------------------------------------------------------------------
// adfp_pkg
// Shared types, character codes, register map and defaults of the ASCII
// distance frame parser.
// ----------------------------------------------------------------------------
package adfp_pkg;

    localparam int FRAME_BYTES_DEF      = 16;
    localparam int DISTANCE_CHARS_DEF   = 5;
    localparam int CONFIDENCE_CHARS_DEF = 2;

    localparam int BYTE_W     = 8;
    localparam int DIST_W     = 16;
    localparam int CONF_W     = 8;
    localparam int OUT_DATA_W = 24;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [CONF_W-1:0] conf_t;

    localparam byte_t CH_SPACE   = 8'h20;
    localparam byte_t CH_COMMA   = 8'h2C;
    localparam byte_t CH_NEWLINE = 8'h0A;
    localparam byte_t CH_TAB     = 8'h09;
    localparam byte_t CH_CR      = 8'h0D;
    localparam byte_t CH_PLUS    = 8'h2B;
    localparam byte_t CH_MINUS   = 8'h2D;
    localparam byte_t CH_ZERO    = 8'h30;
    localparam byte_t CH_NINE    = 8'h39;

    localparam dist_t MIN_DIST_RST = 16'd20;
    localparam dist_t MAX_DIST_RST = 16'd4000;
    localparam conf_t MAX_CONF_RST = 8'd62;

    typedef enum logic [1:0] {
        REG_MIN_DIST = 2'd0,
        REG_MAX_DIST = 2'd1,
        REG_MAX_CONF = 2'd2
    } reg_idx_t;

    typedef struct packed {
        dist_t min_dist;
        dist_t max_dist;
        conf_t max_conf;
    } adfp_cfg_t;

    function automatic logic is_blank(input byte_t c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input byte_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// File: hdl/adfp_regs.sv
// ----------------------------------------------------------------------------
// adfp_regs
// APB register file holding the distance and confidence limits.
// ----------------------------------------------------------------------------
module adfp_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [adfp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [adfp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [adfp_pkg::APB_DATA_W-1:0] prdata,
    output logic                         pready,
    output adfp_pkg::adfp_cfg_t          cfg
);
    import adfp_pkg::*;

    adfp_cfg_t cfg_reg;
    reg_idx_t  idx;
    logic      wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_dist <= MIN_DIST_RST;
            cfg_reg.max_dist <= MAX_DIST_RST;
            cfg_reg.max_conf <= MAX_CONF_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MIN_DIST: cfg_reg.min_dist <= pwdata[DIST_W-1:0];
                REG_MAX_DIST: cfg_reg.max_dist <= pwdata[DIST_W-1:0];
                REG_MAX_CONF: cfg_reg.max_conf <= pwdata[CONF_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MIN_DIST: prdata = APB_DATA_W'(cfg_reg.min_dist);
            REG_MAX_DIST: prdata = APB_DATA_W'(cfg_reg.max_dist);
            REG_MAX_CONF: prdata = APB_DATA_W'(cfg_reg.max_conf);
            default:      prdata = '0;
        endcase
    end

endmodule

// File: hdl/adfp_store.sv
// ----------------------------------------------------------------------------
// adfp_store
// Frame tracker: header/separator state machine and the byte store that
// holds the current frame; read port registered for the converter.
// ----------------------------------------------------------------------------
module adfp_store #(
    parameter int FRAME_BYTES = adfp_pkg::FRAME_BYTES_DEF,
    localparam int AW = $clog2(FRAME_BYTES),
    localparam int CW = $clog2(FRAME_BYTES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_accept,
    input  adfp_pkg::byte_t      in_byte,
    input  logic [AW-1:0]        rd_addr,
    output adfp_pkg::byte_t      rd_data,
    output logic                 conv_start,
    output logic [AW-1:0]        sep_pos,
    output logic [CW-1:0]        fill_count
);
    import adfp_pkg::*;

    typedef enum logic [3:0] {
        PH_HDR  = 4'b0001,
        PH_DIST = 4'b0010,
        PH_SEP  = 4'b0100,
        PH_CONF = 4'b1000
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [CW-1:0]  fill_reg, fill_next;
    logic [AW-1:0]  sep_reg, sep_next;
    logic           full;
    byte_t          mem [FRAME_BYTES];
    byte_t          rd_data_reg;

    assign full       = fill_reg >= CW'(FRAME_BYTES);
    assign sep_pos    = sep_reg;
    assign fill_count = fill_reg;
    assign rd_data    = rd_data_reg;

    always_comb
    begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        sep_next   = sep_reg;
        conv_start = 1'b0;
        if (in_accept)
        begin
            if (full)
            begin
                phase_next = PH_HDR;
                fill_next  = '0;
                sep_next   = '0;
            end
            else
            begin
                fill_next = fill_reg + CW'(1);
                case (phase_reg)
                    PH_HDR:
                    begin
                        if (in_byte == CH_SPACE)
                        begin
                            phase_next = PH_DIST;
                            fill_next  = CW'(1);
                        end
                        else
                        begin
                            fill_next = '0;
                        end
                    end
                    PH_DIST:
                    begin
                        if (in_byte == CH_COMMA)
                        begin
                            phase_next = PH_SEP;
                            sep_next   = fill_reg[AW-1:0];
                        end
                    end
                    PH_SEP:
                    begin
                        if (in_byte == CH_SPACE)
                        begin
                            phase_next = PH_CONF;
                        end
                        else
                        begin
                            phase_next = PH_HDR;
                            fill_next  = '0;
                            sep_next   = '0;
                        end
                    end
                    PH_CONF:
                    begin
                        if (in_byte == CH_NEWLINE)
                        begin
                            conv_start = 1'b1;
                            phase_next = PH_HDR;
                            fill_next  = '0;
                            sep_next   = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HDR;
                        fill_next  = '0;
                        sep_next   = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            fill_reg  <= '0;
            sep_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            sep_reg   <= sep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && !full)
        begin
            mem[fill_reg[AW-1:0]] <= in_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// File: hdl/adfp_convert.sv
// ----------------------------------------------------------------------------
// adfp_convert
// Text-to-number sequencer: walks the stored distance and confidence text
// one byte per cycle through a shared multiply-by-ten accumulator, then
// range-checks and holds the result in the output register.
// ----------------------------------------------------------------------------
module adfp_convert #(
    parameter int FRAME_BYTES      = adfp_pkg::FRAME_BYTES_DEF,
    parameter int DISTANCE_CHARS   = adfp_pkg::DISTANCE_CHARS_DEF,
    parameter int CONFIDENCE_CHARS = adfp_pkg::CONFIDENCE_CHARS_DEF,
    localparam int AW   = $clog2(FRAME_BYTES),
    localparam int CW   = $clog2(FRAME_BYTES + 1),
    localparam int XW   = CW + 1,
    localparam int MAXC = (DISTANCE_CHARS > CONFIDENCE_CHARS) ?
                          DISTANCE_CHARS : CONFIDENCE_CHARS,
    localparam int LW   = $clog2(MAXC + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  adfp_pkg::adfp_cfg_t  cfg,
    input  logic                 start,
    input  logic [AW-1:0]        sep_pos,
    input  logic [CW-1:0]        fill_count,
    input  adfp_pkg::byte_t      rd_data,
    output logic [AW-1:0]        rd_addr,
    output logic                 idle,
    input  logic                 out_ready,
    output logic                 out_valid,
    output adfp_pkg::dist_t      out_dist,
    output adfp_pkg::conf_t      out_conf,
    output logic                 out_in_range
);
    import adfp_pkg::*;

    typedef enum logic [2:0] {
        CV_IDLE  = 3'b001,
        CV_CHAR  = 3'b010,
        CV_CHECK = 3'b100
    } cv_state_t;

    cv_state_t      state_reg, state_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [LW-1:0]  cnt_reg, cnt_next;
    logic [LW-1:0]  clen_reg, clen_next;
    logic [CW-1:0]  cstart_reg, cstart_next;
    logic           field_reg, field_next;
    logic           lead_reg, lead_next;
    logic           neg_reg, neg_next;
    dist_t          acc_reg, acc_next;
    dist_t          dist_reg, dist_next;
    conf_t          conf_reg, conf_next;
    logic           out_valid_reg;
    dist_t          out_dist_reg;
    conf_t          out_conf_reg;
    logic           out_ok_reg;
    logic           load;
    logic           ok;

    logic [CW-1:0]  dlen_raw;
    logic [XW-1:0]  cend;
    logic [XW-1:0]  clen_raw;
    logic [LW-1:0]  dlen;
    logic [LW-1:0]  clen;
    logic [CW-1:0]  cstart;
    dist_t          mac;
    dist_t          val;

    assign dlen_raw = (sep_pos != '0) ? (CW'(sep_pos) - CW'(1)) : '0;
    assign dlen     = (dlen_raw > CW'(DISTANCE_CHARS)) ? LW'(DISTANCE_CHARS)
                                                       : LW'(dlen_raw);
    assign cend     = XW'(sep_pos) + XW'(2);
    assign clen_raw = (XW'(fill_count) >= cend) ? (XW'(fill_count) - cend) : '0;
    assign clen     = (clen_raw > XW'(CONFIDENCE_CHARS)) ? LW'(CONFIDENCE_CHARS)
                                                         : LW'(clen_raw);
    assign cstart   = CW'(cend);

    assign mac = DIST_W'({acc_reg, 3'b000}) + DIST_W'({acc_reg, 1'b0})
               + DIST_W'(rd_data[3:0]);
    assign val = neg_reg ? (~acc_reg + DIST_W'(1)) : acc_reg;

    assign ok = (dist_reg >= cfg.min_dist) && (dist_reg <= cfg.max_dist)
             && (conf_reg <= cfg.max_conf);

    assign rd_addr      = idx_next[AW-1:0];
    assign idle         = (state_reg == CV_IDLE);
    assign load         = (state_reg == CV_CHECK) && (!out_valid_reg || out_ready);
    assign out_valid    = out_valid_reg;
    assign out_dist     = out_dist_reg;
    assign out_conf     = out_conf_reg;
    assign out_in_range = out_ok_reg;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        clen_next   = clen_reg;
        cstart_next = cstart_reg;
        field_next  = field_reg;
        lead_next   = lead_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        dist_next   = dist_reg;
        conf_next   = conf_reg;
        case (state_reg)
            CV_IDLE:
            begin
                if (start)
                begin
                    idx_next    = CW'(1);
                    cnt_next    = dlen;
                    clen_next   = clen;
                    cstart_next = cstart;
                    field_next  = 1'b0;
                    lead_next   = 1'b1;
                    neg_next    = 1'b0;
                    acc_next    = '0;
                    state_next  = CV_CHAR;
                end
            end
            CV_CHAR:
            begin
                if (cnt_reg == '0)
                begin
                    if (!field_reg)
                    begin
                        dist_next  = val;
                        field_next = 1'b1;
                        idx_next   = cstart_reg;
                        cnt_next   = clen_reg;
                        lead_next  = 1'b1;
                        neg_next   = 1'b0;
                        acc_next   = '0;
                    end
                    else
                    begin
                        conf_next  = val[CONF_W-1:0];
                        state_next = CV_CHECK;
                    end
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    cnt_next = cnt_reg - LW'(1);
                    if (is_digit(rd_data))
                    begin
                        acc_next  = mac;
                        lead_next = 1'b0;
                    end
                    else if (lead_reg && is_blank(rd_data))
                    begin
                        lead_next = 1'b1;
                    end
                    else if (lead_reg && ((rd_data == CH_PLUS) || (rd_data == CH_MINUS)))
                    begin
                        neg_next  = (rd_data == CH_MINUS);
                        lead_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next = '0;
                    end
                end
            end
            CV_CHECK:
            begin
                if (load)
                begin
                    state_next = CV_IDLE;
                end
            end
            default:
            begin
                state_next = CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CV_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            field_reg     <= 1'b0;
            lead_reg      <= 1'b1;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            field_reg <= field_next;
            lead_reg  <= lead_next;
            neg_reg   <= neg_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        clen_reg   <= clen_next;
        cstart_reg <= cstart_next;
        acc_reg    <= acc_next;
        dist_reg   <= dist_next;
        conf_reg   <= conf_next;
        if (load)
        begin
            out_dist_reg <= ok ? dist_reg : '0;
            out_conf_reg <= ok ? conf_reg : '0;
            out_ok_reg   <= ok;
        end
    end

endmodule

// File: hdl/ascii_distance_frame_parser_core.sv
// ----------------------------------------------------------------------------
// ascii_distance_frame_parser_core
// Conversion: after the newline that ends a frame, the converter walks the stored
//   distance text (up to DISTANCE_CHARS) and confidence text (up to CONFIDENCE_CHARS)
//   one stored byte per cycle, fewer if a text ends early, then loads the result.
// Throughput: one byte per cycle outside conversion; s_tready is low while
//   a frame converts and while its result waits for a full output register.
// Reset: rst_n asynchronous, active low; limits return to 20/4000/62.
// ----------------------------------------------------------------------------
module ascii_distance_frame_parser_core #(
    parameter int FRAME_BYTES      = adfp_pkg::FRAME_BYTES_DEF,
    parameter int DISTANCE_CHARS   = adfp_pkg::DISTANCE_CHARS_DEF,
    parameter int CONFIDENCE_CHARS = adfp_pkg::CONFIDENCE_CHARS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [adfp_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] rx_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [adfp_pkg::OUT_DATA_W-1:0]     m_tdata,   // [15:0] distance_mm, [23:16] confidence
    output logic                                m_tuser,   // [0] in_range
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [adfp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [adfp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [adfp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import adfp_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int CW = $clog2(FRAME_BYTES + 1);

    adfp_cfg_t      cfg;
    logic           in_accept;
    logic           conv_start;
    logic           conv_idle;
    logic [AW-1:0]  rd_addr;
    byte_t          rd_data;
    logic [AW-1:0]  sep_pos;
    logic [CW-1:0]  fill_count;
    dist_t          out_dist;
    conf_t          out_conf;

    assign s_tready  = conv_idle;
    assign in_accept = s_tvalid && s_tready;
    assign m_tdata   = {out_conf, out_dist};

    adfp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    adfp_store #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .in_byte    (s_tdata),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .conv_start (conv_start),
        .sep_pos    (sep_pos),
        .fill_count (fill_count)
    );

    adfp_convert #(
        .FRAME_BYTES      (FRAME_BYTES),
        .DISTANCE_CHARS   (DISTANCE_CHARS),
        .CONFIDENCE_CHARS (CONFIDENCE_CHARS)
    ) u_convert (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .start        (conv_start),
        .sep_pos      (sep_pos),
        .fill_count   (fill_count),
        .rd_data      (rd_data),
        .rd_addr      (rd_addr),
        .idle         (conv_idle),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_dist     (out_dist),
        .out_conf     (out_conf),
        .out_in_range (m_tuser)
    );

endmodule

// File: hdl/adfp_checker.sv
// ----------------------------------------------------------------------------
// adfp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module adfp_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [adfp_pkg::BYTE_W-1:0]         s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [adfp_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                m_tuser
);
    import adfp_pkg::*;

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // out-of-range frames report zeros
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("out-of-range result carries nonzero data");

    // only a newline can start a conversion
    a_nl_only: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata != CH_NEWLINE) |=> !$rose(m_tvalid))
        else $error("result without newline");

    // a new result follows a busy converter
    a_busy_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while input side idle");

endmodule

bind ascii_distance_frame_parser_core adfp_checker u_adfp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
